### hdl/rclip_pkg.sv
`timescale 1ns / 1ps
// rclip_pkg: types, constants and helpers for the textured rectangle clipper
// used by rclip_scale, rclip_axis and textured_rect_clip; depends on nothing
package rclip_pkg;

   // quotient bits produced by the texture scaler, one per divider stage
   localparam int DIV_BITS = 26;
   // remainder width: divisor magnitude reaches 2^32
   localparam int REM_W = 33;
   localparam int WORK_W = REM_W + DIV_BITS;
   // scaler: diff, multiply, magnitude, range check, divider stages, final add
   localparam int SCL_LAT = DIV_BITS + 5;
   // axis: prep stage, then near edge scaler, then far edge scaler
   localparam int AX_LAT = 1 + 2 * SCL_LAT;

   typedef enum logic [2:0] {
      CSR_CLIP_ENABLE = 3'd0,
      CSR_CLIP_LEFT   = 3'd1,
      CSR_CLIP_TOP    = 3'd2,
      CSR_CLIP_RIGHT  = 3'd3,
      CSR_CLIP_BOTTOM = 3'd4
   } csr_index_type;

   localparam logic [2:0] RMODE_REQ0 = 3'd3;
   localparam logic [2:0] RMODE_REQ1 = 3'd1;
   localparam logic [2:0] RMODE_REQ2 = 3'd0;
   localparam logic [2:0] RMODE_REQ3 = 3'd4;
   localparam logic [2:0] RMODE_REQ4 = 3'd6;
   localparam logic [2:0] RMODE_KEEP = 3'd7;

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [23:0] tex_left;
      logic signed [23:0] tex_top;
      logic signed [23:0] tex_right;
      logic signed [23:0] tex_bottom;
      logic [31:0]        tint_color;
      logic [2:0]         blend_select;
      logic               rotated;
   } rclip_req_type;

   typedef struct packed {
      logic signed [31:0] out_left;
      logic signed [31:0] out_top;
      logic signed [31:0] out_right;
      logic signed [31:0] out_bottom;
      logic signed [23:0] out_tex_left;
      logic signed [23:0] out_tex_top;
      logic signed [23:0] out_tex_right;
      logic signed [23:0] out_tex_bottom;
      logic [31:0]        out_color;
      logic [2:0]         render_mode;
      logic               out_rotated;
   } rclip_rsp_type;

   // one clipped axis leaving rclip_axis
   typedef struct packed {
      logic signed [31:0] o_lo;
      logic signed [31:0] o_hi;
      logic signed [23:0] t_lo;
      logic signed [23:0] t_hi;
      logic               drop;
   } rclip_axis_type;

   // payload carried through the divider stages
   typedef struct packed {
      logic [WORK_W-1:0]  work;
      logic [REM_W-1:0]   dmag;
      logic signed [23:0] base;
      logic               neg;
      logic               ovf;
      logic               apply;
   } rclip_div_type;

   // pass-through fields of one draw
   typedef struct packed {
      logic [31:0] color;
      logic [2:0]  mode;
      logic        rotated;
   } rclip_side_type;

   function automatic logic [2:0] map_mode(input logic [2:0] req);
      logic [2:0] m;
      case (req)
         3'd0:    m = RMODE_REQ0;
         3'd1:    m = RMODE_REQ1;
         3'd2:    m = RMODE_REQ2;
         3'd3:    m = RMODE_REQ3;
         3'd4:    m = RMODE_REQ4;
         default: m = RMODE_KEEP;
      endcase
      return m;
   endfunction

   // one restoring division step: remainder in the top bits, quotient shifts in low
   function automatic logic [WORK_W-1:0] div_step(input logic [WORK_W-1:0] work,
                                                  input logic [REM_W-1:0] dmag);
      logic [REM_W:0]   trial;
      logic [REM_W-1:0] nrem;
      logic             qb;
      trial = {work[WORK_W-1:DIV_BITS], work[DIV_BITS-1]};
      if (trial >= {1'b0, dmag}) begin
         nrem = REM_W'(trial - {1'b0, dmag});
         qb   = 1'b1;
      end else begin
         nrem = trial[REM_W-1:0];
         qb   = 1'b0;
      end
      return {nrem, work[DIV_BITS-2:0], qb};
   endfunction

endpackage

### hdl/rclip_delay.sv
`timescale 1ns / 1ps
// rclip_delay: enabled shift line that keeps side data aligned with the scalers
// no package dependency
module rclip_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] line_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (adv) begin
         line_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign q = line_ff[DEPTH-1];

endmodule

### hdl/rclip_scale.sv
`timescale 1ns / 1ps
// rclip_scale: pipelined base + (far - base) * num / den with saturation
// depends on rclip_pkg
module rclip_scale (
   input  logic               clock,
   input  logic               adv,
   input  logic               apply,
   input  logic signed [23:0] base,
   input  logic signed [23:0] far,
   input  logic signed [32:0] num,
   input  logic signed [32:0] den,
   output logic signed [23:0] result
);

   localparam int DB = rclip_pkg::DIV_BITS;
   localparam int WW = rclip_pkg::WORK_W;
   localparam int RW = rclip_pkg::REM_W;

   // stage 1: texture difference
   logic signed [24:0] s1_diff_ff;
   logic signed [32:0] s1_num_ff, s1_den_ff;
   logic signed [23:0] s1_base_ff;
   logic               s1_apply_ff;
   // stage 2: product
   logic signed [57:0] s2_prod_ff, s2_prod_in;
   logic signed [32:0] s2_den_ff;
   logic signed [23:0] s2_base_ff;
   logic               s2_apply_ff;
   // stage 3: magnitudes
   logic [57:0]        s3_pmag_ff;
   logic [RW-1:0]      s3_dmag_ff;
   logic signed [23:0] s3_base_ff;
   logic               s3_neg_ff, s3_apply_ff;
   // range check and divider stages
   rclip_pkg::rclip_div_type dv_ff [DB+1];
   rclip_pkg::rclip_div_type dv_in [DB+1];
   rclip_pkg::rclip_div_type dv0_in;
   // final
   logic [DB:0]        qmag;
   logic signed [DB+1:0] qsig;
   logic signed [DB+2:0] sum;
   logic signed [23:0] sat, result_ff, result_in;

   assign s2_prod_in = s1_diff_ff * s1_num_ff;

   always_comb begin
      dv0_in       = '0;
      dv0_in.ovf   = {1'b0, s3_pmag_ff} >= {s3_dmag_ff, DB'(0)};
      dv0_in.work  = {1'b0, s3_pmag_ff};
      dv0_in.dmag  = s3_dmag_ff;
      dv0_in.base  = s3_base_ff;
      dv0_in.neg   = s3_neg_ff;
      dv0_in.apply = s3_apply_ff;
   end

   // next value of every divider stage
   always_comb begin
      dv_in[0] = dv0_in;
      for (int k = 1; k <= DB; k++) begin
         dv_in[k]      = dv_ff[k-1];
         dv_in[k].work = rclip_pkg::div_step(dv_ff[k-1].work, dv_ff[k-1].dmag);
      end
   end

   always_comb begin
      qmag = dv_ff[DB].ovf ? {1'b1, DB'(0)} : {1'b0, dv_ff[DB].work[DB-1:0]};
      qsig = dv_ff[DB].neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      sum  = {{(DB-21){dv_ff[DB].base[23]}}, dv_ff[DB].base} + {qsig[DB+1], qsig};
      if (sum > $signed((DB+3)'(24'sh7fffff))) begin
         sat = 24'sh7fffff;
      end else if (sum < $signed((DB+3)'(24'sh800000))) begin
         sat = 24'sh800000;
      end else begin
         sat = sum[23:0];
      end
      result_in = dv_ff[DB].apply ? sat : dv_ff[DB].base;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_diff_ff  <= {far[23], far} - {base[23], base};
         s1_num_ff   <= num;
         s1_den_ff   <= den;
         s1_base_ff  <= base;
         s1_apply_ff <= apply && (den != '0);

         s2_prod_ff  <= s2_prod_in;
         s2_den_ff   <= s1_den_ff;
         s2_base_ff  <= s1_base_ff;
         s2_apply_ff <= s1_apply_ff;

         s3_pmag_ff  <= s2_prod_ff[57] ? 58'(-s2_prod_ff) : s2_prod_ff;
         s3_dmag_ff  <= s2_den_ff[32] ? RW'(-s2_den_ff) : s2_den_ff;
         s3_neg_ff   <= s2_prod_ff[57] ^ s2_den_ff[32];
         s3_base_ff  <= s2_base_ff;
         s3_apply_ff <= s2_apply_ff;

         for (int k = 0; k <= DB; k++) begin
            dv_ff[k] <= dv_in[k];
         end

         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

### hdl/rclip_axis.sv
`timescale 1ns / 1ps
// rclip_axis: clips one axis of a draw and adjusts its two texture coordinates
// depends on rclip_pkg, rclip_scale, rclip_delay
module rclip_axis (
   input  logic               clock,
   input  logic               adv,
   input  logic               en,
   input  logic signed [15:0] clip_lo,
   input  logic signed [15:0] clip_hi,
   input  logic signed [31:0] s,
   input  logic signed [31:0] e,
   input  logic signed [23:0] t_near,
   input  logic signed [23:0] t_far,
   output rclip_pkg::rclip_axis_type res
);

   localparam int L = rclip_pkg::SCL_LAT;

   typedef struct packed {
      logic signed [23:0] t_far;
      logic signed [32:0] num_hi;
      logic signed [32:0] den;
      logic               cond_hi;
      logic signed [31:0] o_lo;
      logic signed [31:0] o_hi;
      logic               drop;
   } mid_type;

   typedef struct packed {
      logic signed [23:0] t_lo;
      logic signed [23:0] t_far;
      logic               cond_hi;
      logic signed [31:0] o_lo;
      logic signed [31:0] o_hi;
      logic               drop;
   } tail_type;

   logic signed [32:0] cl, ch, s33, e33;
   logic signed [32:0] num_lo_ff, num_hi_ff, den_ff;
   logic signed [23:0] t_near_ff, t_far_ff;
   logic signed [31:0] o_lo_ff, o_hi_ff;
   logic               cond_lo_ff, cond_hi_ff, drop_ff;
   logic signed [23:0] t_lo_a, t_hi_b;
   mid_type            mid_in, mid_d;
   tail_type           tail_in, tail_d;

   assign cl  = {{9{clip_lo[15]}}, clip_lo, 8'h00};
   assign ch  = {{9{clip_hi[15]}}, clip_hi, 8'h00};
   assign s33 = {s[31], s};
   assign e33 = {e[31], e};

   always_ff @(posedge clock) begin
      if (adv) begin
         cond_lo_ff <= en && (s33 < cl);
         cond_hi_ff <= en && (e33 > ch);
         drop_ff    <= en && (e33 <= cl);
         num_lo_ff  <= cl - s33;
         num_hi_ff  <= ch - s33;
         den_ff     <= e33 - s33;
         t_near_ff  <= t_near;
         t_far_ff   <= t_far;
         o_lo_ff    <= (en && (s33 < cl)) ? cl[31:0] : s;
         o_hi_ff    <= (en && (e33 > ch)) ? ch[31:0] : e;
      end
   end

   // near edge first
   rclip_scale u_scale_lo (
      .clock  (clock),
      .adv    (adv),
      .apply  (cond_lo_ff),
      .base   (t_near_ff),
      .far    (t_far_ff),
      .num    (num_lo_ff),
      .den    (den_ff),
      .result (t_lo_a)
   );

   assign mid_in = '{t_far: t_far_ff, num_hi: num_hi_ff, den: den_ff, cond_hi: cond_hi_ff,
                     o_lo: o_lo_ff, o_hi: o_hi_ff, drop: drop_ff};

   rclip_delay #(.WIDTH($bits(mid_type)), .DEPTH(L)) u_mid (
      .clock (clock),
      .adv   (adv),
      .d     (mid_in),
      .q     (mid_d)
   );

   // far edge follows the already adjusted near coordinate
   rclip_scale u_scale_hi (
      .clock  (clock),
      .adv    (adv),
      .apply  (mid_d.cond_hi),
      .base   (t_lo_a),
      .far    (mid_d.t_far),
      .num    (mid_d.num_hi),
      .den    (mid_d.den),
      .result (t_hi_b)
   );

   assign tail_in = '{t_lo: t_lo_a, t_far: mid_d.t_far, cond_hi: mid_d.cond_hi,
                      o_lo: mid_d.o_lo, o_hi: mid_d.o_hi, drop: mid_d.drop};

   rclip_delay #(.WIDTH($bits(tail_type)), .DEPTH(L)) u_tail (
      .clock (clock),
      .adv   (adv),
      .d     (tail_in),
      .q     (tail_d)
   );

   // unclamped far edge keeps its own coordinate
   always_comb begin
      res.o_lo = tail_d.o_lo;
      res.o_hi = tail_d.o_hi;
      res.t_lo = tail_d.t_lo;
      res.t_hi = tail_d.cond_hi ? t_hi_b : tail_d.t_far;
      res.drop = tail_d.drop;
   end

endmodule

### hdl/textured_rect_clip.sv
`timescale 1ns / 1ps
// textured_rect_clip: top level of the sprite rectangle clipper
// depends on rclip_pkg, rclip_axis, rclip_delay
//
// Clips one textured sprite draw per clock against a programmable window.
// Every draw goes from request beat to result beat through a prep stage,
// two 31-stage texture scalers in series per axis, and the output
// register; a new beat is taken every cycle while the result side
// is not stalled. The latency is set by the texture scalers: each forms
// (far - near) * span / width with a multiplier and a one-bit-per-stage
// divider of 26 stages, and the far edge scaler waits for the near one.
// Clipping off passes draw coordinates unchanged. A draw lying fully left
// of or above the window gives no result beat. The whole pipe advances as
// one; a held result stalled on rsp freezes it and back-pressures req in
// the same cycle. Write the csr registers only while no draw is in flight.
module textured_rect_clip (
   input  logic                     clock,
   input  logic                     reset,
   // request beats
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rclip_pkg::rclip_req_type req_data,
   // result beats
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rclip_pkg::rclip_rsp_type rsp_data,
   // register writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_wdata
);

   localparam int AL = rclip_pkg::AX_LAT;

   // clip window registers
   logic               clip_en_ff;
   logic signed [15:0] clip_left_ff, clip_top_ff, clip_right_ff, clip_bottom_ff;

   // pipeline control
   logic               adv;
   logic [AL-1:0]      vld_ff;
   logic               rsp_vld_ff, rsp_vld_in;
   rclip_pkg::rclip_rsp_type rsp_ff, rsp_in;

   rclip_pkg::rclip_axis_type ax_x, ax_y;
   rclip_pkg::rclip_side_type side_in, side_d;

   // whole pipe moves unless a finished beat is held at the output
   assign adv       = !(rsp_vld_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_en_ff     <= 1'b0;
         clip_left_ff   <= 16'sd0;
         clip_top_ff    <= 16'sd0;
         clip_right_ff  <= 16'sd32767;
         clip_bottom_ff <= 16'sd32767;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rclip_pkg::CSR_CLIP_ENABLE: clip_en_ff     <= csr_wdata[0];
            rclip_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
            rclip_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata;
            rclip_pkg::CSR_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
            rclip_pkg::CSR_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits follow the data down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[AL-2:0], req_valid};
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // horizontal axis: left and right edges
   rclip_axis u_axis_x (
      .clock   (clock),
      .adv     (adv),
      .en      (clip_en_ff),
      .clip_lo (clip_left_ff),
      .clip_hi (clip_right_ff),
      .s       (req_data.start_x),
      .e       (req_data.end_x),
      .t_near  (req_data.tex_left),
      .t_far   (req_data.tex_right),
      .res     (ax_x)
   );

   // vertical axis: top and bottom edges
   rclip_axis u_axis_y (
      .clock   (clock),
      .adv     (adv),
      .en      (clip_en_ff),
      .clip_lo (clip_top_ff),
      .clip_hi (clip_bottom_ff),
      .s       (req_data.start_y),
      .e       (req_data.end_y),
      .t_near  (req_data.tex_top),
      .t_far   (req_data.tex_bottom),
      .res     (ax_y)
   );

   // colour, translated mode and rotate flag ride alongside
   assign side_in = '{color: req_data.tint_color,
                      mode: rclip_pkg::map_mode(req_data.blend_select),
                      rotated: req_data.rotated};

   rclip_delay #(.WIDTH($bits(rclip_pkg::rclip_side_type)), .DEPTH(AL)) u_side (
      .clock (clock),
      .adv   (adv),
      .d     (side_in),
      .q     (side_d)
   );

   // output register: dropped draws leave a bubble
   always_comb begin
      rsp_vld_in            = vld_ff[AL-1] && !ax_x.drop && !ax_y.drop;
      rsp_in.out_left       = ax_x.o_lo;
      rsp_in.out_top        = ax_y.o_lo;
      rsp_in.out_right      = ax_x.o_hi;
      rsp_in.out_bottom     = ax_y.o_hi;
      rsp_in.out_tex_left   = ax_x.t_lo;
      rsp_in.out_tex_top    = ax_y.t_lo;
      rsp_in.out_tex_right  = ax_x.t_hi;
      rsp_in.out_tex_bottom = ax_y.t_hi;
      rsp_in.out_color      = side_d.color;
      rsp_in.render_mode    = side_d.mode;
      rsp_in.out_rotated    = side_d.rotated;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a held result freezes the pipe valid bits
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(vld_ff))
      else $error("pipe valid bits moved during stall");

   // an accepted request enters the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted beat lost at pipe entry");

   // a new result only comes from the last stage
   a_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(vld_ff[AL-1]))
      else $error("result beat without a draw behind it");
`endif

endmodule
